// ----- hw/rtl/frustum_point_box_cull_unit_defines.svh -----
// Assertion macros shared by the frustum cull RTL.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef FRUSTUM_POINT_BOX_CULL_UNIT_DEFINES_SVH
`define FRUSTUM_POINT_BOX_CULL_UNIT_DEFINES_SVH

// same-cycle implication
`define FPBC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FPBC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/fpbc_pkg.sv -----
// Types and constants for the frustum cull unit.
// No dependencies.
`timescale 1ns / 1ps
package fpbc_pkg;
	localparam int unsigned PLANES = 6;
	localparam int unsigned AXES = 3;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_POINT = 2'd1;
	localparam logic [1:0] MODE_BOX   = 2'd2;

	typedef logic signed [31:0] q16_t;   // Q16.16 value
	typedef logic signed [32:0] coef_t;  // plane coefficient, one bit of growth
	typedef logic signed [64:0] prod_t;  // coef_t * q16_t

	// matrix column combined with column 3 for each plane
	function automatic logic [1:0] plane_col(input int unsigned p);
		case (p)
			0, 1:    plane_col = 2'd2;
			2, 3:    plane_col = 2'd0;
			default: plane_col = 2'd1;
		endcase
	endfunction

	// 1 when the column is added, 0 when subtracted
	function automatic logic plane_add(input int unsigned p);
		case (p)
			0, 2, 5: plane_add = 1'b1;
			default: plane_add = 1'b0;
		endcase
	endfunction
endpackage

// ----- hw/rtl/fpbc_plane.sv -----
// One clip plane: multiply stage, then sum and sign stage.
// Depends on fpbc_pkg and frustum_point_box_cull_unit_defines.svh.
`timescale 1ns / 1ps
`include "frustum_point_box_cull_unit_defines.svh"
module fpbc_plane (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   adv,
	input  fpbc_pkg::coef_t                        coef_s1 [fpbc_pkg::AXES],
	input  fpbc_pkg::coef_t                        w_s1,
	input  fpbc_pkg::q16_t                         pt_s1 [fpbc_pkg::AXES],
	output logic                                   behind_s3
);
	fpbc_pkg::prod_t prod_s2 [fpbc_pkg::AXES];
	fpbc_pkg::coef_t w_s2;
	logic signed [67:0] plane_dist;

	// one multiply per axis, registered
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < fpbc_pkg::AXES; a++) begin
				prod_s2[a] <= fpbc_pkg::prod_t'(coef_s1[a] * pt_s1[a]);
			end
			w_s2 <= w_s1;
		end
	end

	// add the three products and the offset at Q32.32 scale
	assign plane_dist = 68'(prod_s2[0]) + 68'(prod_s2[1]) + 68'(prod_s2[2])
		+ (68'(w_s2) <<< 16);

	always_ff @(posedge clk) begin
		if (adv) begin
			behind_s3 <= plane_dist[67];
		end
	end

	`FPBC_ASSERT_NEXT(a_plane_hold, !adv && arst_n, $stable(behind_s3), "plane result moved in stall")
endmodule

// ----- hw/rtl/frustum_point_box_cull_unit.sv -----
// Top level of the frustum cull unit: matrix store, corner select, pipeline control.
// Depends on fpbc_pkg, fpbc_plane and frustum_point_box_cull_unit_defines.svh.
`timescale 1ns / 1ps
`include "frustum_point_box_cull_unit_defines.svh"
// Usage:
//  The slave stream takes one word per item. tuser carries the mode: load a
//  matrix element, test a point or test an axis-aligned box. Load words write
//  the 4x4 view-projection matrix at once and give no result; the next word
//  already sees the new element. Mode three is dropped.
//  Point and box words each give one master word: tdata bit 0 is visible.
//  A box is tested per plane against its corner farthest in front, which
//  answers the same as checking all eight corners.
//  Path: a word passes coefficient/corner select, multiply, and sum and sign
//  before its result lands in the output register.
//  Throughput: one word per cycle while the output is not stalled, set by the
//  six plane units running in parallel, each a multiply stage and an add stage.
//  Stall: the whole pipeline holds while the output word waits and
//  m_tready is low; an empty output stage still lets words advance.
//  Reset: the matrix returns to identity, all valid bits clear.
module frustum_point_box_cull_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// row[1:0], col[3:2], value[35:4], min_x[67:36], min_y[99:68], min_z[131:100],
	// max_x[163:132], max_y[195:164], max_z[227:196], zero fill[231:228]
	input  logic [231:0] s_tdata,
	// mode[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// visible[0], zero fill[7:1]
	output logic [7:0]   m_tdata
);
	fpbc_pkg::q16_t mat_q [16];
	logic adv, in_acc, is_load, is_test, is_box;
	logic v_s1, v_s2, v_s3;
	logic [1:0] row, col;
	fpbc_pkg::q16_t value;
	fpbc_pkg::q16_t lo [fpbc_pkg::AXES];
	fpbc_pkg::q16_t hi [fpbc_pkg::AXES];
	fpbc_pkg::coef_t coef [fpbc_pkg::PLANES][4];
	fpbc_pkg::coef_t coef_s1 [fpbc_pkg::PLANES][fpbc_pkg::AXES];
	fpbc_pkg::coef_t w_s1 [fpbc_pkg::PLANES];
	fpbc_pkg::q16_t pt_s1 [fpbc_pkg::PLANES][fpbc_pkg::AXES];
	logic [fpbc_pkg::PLANES-1:0] behind_s3;

	assign row   = s_tdata[1:0];
	assign col   = s_tdata[3:2];
	assign value = s_tdata[35:4];
	always_comb begin
		for (int a = 0; a < fpbc_pkg::AXES; a++) begin
			lo[a] = s_tdata[36 + 32*a +: 32];
			hi[a] = s_tdata[132 + 32*a +: 32];
		end
	end

	// advance whenever the output stage is empty or being drained
	assign adv      = !v_s3 || m_tready;
	assign s_tready = adv;
	assign in_acc   = s_tvalid && s_tready;
	assign is_load  = s_tuser == fpbc_pkg::MODE_LOAD;
	assign is_box   = s_tuser == fpbc_pkg::MODE_BOX;
	assign is_test  = (s_tuser == fpbc_pkg::MODE_POINT) || is_box;

	// matrix store, identity at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				mat_q[i] <= (i % 5 == 0) ? 32'sh0001_0000 : 32'sh0;
			end
		end else if (in_acc && is_load) begin
			mat_q[{row, col}] <= value;
		end
	end

	// plane coefficients from the current matrix
	always_comb begin
		for (int p = 0; p < fpbc_pkg::PLANES; p++) begin
			for (int r = 0; r < 4; r++) begin
				if (fpbc_pkg::plane_add(p)) begin
					coef[p][r] = fpbc_pkg::coef_t'(mat_q[4*r + 3])
						+ fpbc_pkg::coef_t'(mat_q[4*r + 32'(fpbc_pkg::plane_col(p))]);
				end else begin
					coef[p][r] = fpbc_pkg::coef_t'(mat_q[4*r + 3])
						- fpbc_pkg::coef_t'(mat_q[4*r + 32'(fpbc_pkg::plane_col(p))]);
				end
			end
		end
	end

	// stage 1: latch coefficients and the corner farthest in front per plane
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int p = 0; p < fpbc_pkg::PLANES; p++) begin
				w_s1[p] <= coef[p][3];
				for (int a = 0; a < fpbc_pkg::AXES; a++) begin
					coef_s1[p][a] <= coef[p][a];
					if (!is_box) begin
						pt_s1[p][a] <= lo[a];
					end else if ((coef[p][a] < 0) == (hi[a] > lo[a])) begin
						pt_s1[p][a] <= lo[a];
					end else begin
						pt_s1[p][a] <= hi[a];
					end
				end
			end
		end
	end

	// valid bits follow the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_acc && is_test;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	for (genvar p = 0; p < fpbc_pkg::PLANES; p++) begin : g_plane
		fpbc_plane u_plane (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.coef_s1   (coef_s1[p]),
			.w_s1      (w_s1[p]),
			.pt_s1     (pt_s1[p]),
			.behind_s3 (behind_s3[p])
		);
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = {7'b0, ~|behind_s3};

	`FPBC_ASSERT_NEXT(a_load_no_result, in_acc && is_load, !v_s1, "load word entered pipeline")
	`FPBC_ASSERT_NEXT(a_s1_to_s2, adv && v_s1, v_s2, "item lost between stage 1 and 2")
	`FPBC_ASSERT_NEXT(a_stall_hold, !adv, v_s3 && $stable(m_tdata), "output moved in stall")
	`FPBC_ASSERT_NOW(a_ready_free, !v_s3, s_tready, "not ready with empty output")
endmodule

// ----- tb/tb_top.sv -----
// Testbench for frustum_point_box_cull_unit: matrix loads, point and box cull tests.
// Depends on fpbc_pkg and the unit RTL; predicts visibility with its own plane math.
`timescale 1ns / 1ps
module tb_top;
	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [231:0] s_tdata = '0;    // row, col, value, min_x..z, max_x..z, zero fill
	logic [1:0]   s_tuser = '0;    // mode
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [7:0]   m_tdata;         // visible, zero fill

	frustum_point_box_cull_unit uut (.*);

	always #5 clk = ~clk;

	// predictor state: its own copy of the view-projection matrix
	logic signed [31:0] view_mat [4][4];
	logic visible_queue [$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit recv_hold = 1'b0;
	int failures = 0;
	int words_sent = 0;
	int results_seen = 0;
	int boxes_sent = 0;
	int points_sent = 0;
	int loads_sent = 0;

	// column paired with column 3, and add or subtract, per plane
	function automatic int plane_column(int p);
		int cols [6] = '{2, 2, 0, 0, 1, 1};
		return cols[p];
	endfunction

	function automatic bit plane_plus(int p);
		bit adds [6] = '{1, 0, 1, 0, 0, 1};
		return adds[p];
	endfunction

	// true when the point lies strictly behind plane p
	function automatic bit point_behind(int p, logic signed [31:0] pt [3]);
		logic signed [127:0] dist_acc;
		logic signed [33:0] coef;
		dist_acc = '0;
		for (int r = 0; r < 4; r++) begin
			if (plane_plus(p))
				coef = 34'(view_mat[r][3]) + 34'(view_mat[r][plane_column(p)]);
			else
				coef = 34'(view_mat[r][3]) - 34'(view_mat[r][plane_column(p)]);
			if (r < 3)
				dist_acc += 128'(coef) * 128'(pt[r]);
			else
				dist_acc += 128'(coef) <<< 16;
		end
		return dist_acc < 0;
	endfunction

	function automatic bit predict_visible(logic [1:0] mode, logic signed [31:0] lo [3],
			logic signed [31:0] hi [3]);
		logic signed [31:0] corner [3];
		int behind_count;
		for (int p = 0; p < 6; p++) begin
			if (mode == fpbc_pkg::MODE_POINT) begin
				if (point_behind(p, lo))
					return 1'b0;
			end else begin
				behind_count = 0;
				for (int k = 0; k < 8; k++) begin
					corner[0] = k[0] ? hi[0] : lo[0];
					corner[1] = k[1] ? hi[1] : lo[1];
					corner[2] = k[2] ? hi[2] : lo[2];
					if (point_behind(p, corner))
						behind_count++;
				end
				if (behind_count == 8)
					return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// send one word; update the predicted matrix or queue the expected visibility
	task automatic send_word(logic [1:0] mode, logic [1:0] row, logic [1:0] col,
			logic [31:0] value, logic signed [31:0] lo [3], logic signed [31:0] hi [3]);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {4'b0, hi[2], hi[1], hi[0], lo[2], lo[1], lo[0], value, col, row};
		do @(posedge clk); while (!s_tready);
		words_sent++;
		if (mode == fpbc_pkg::MODE_LOAD) begin
			view_mat[row][col] = value;
			loads_sent++;
		end else if (mode != 2'd3) begin
			visible_queue.push_back(predict_visible(mode, lo, hi));
			if (mode == fpbc_pkg::MODE_BOX) boxes_sent++; else points_sent++;
		end
	endtask

	// receiver: random stalls, plus a long hold when asked
	always @(posedge clk) begin
		if (arst_n)
			m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
	end

	// compare each accepted word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (visible_queue.size() == 0) begin
				$error("visible: unexpected result %0d", m_tdata[0]);
				failures++;
			end else begin
				logic exp_vis;
				exp_vis = visible_queue.pop_front();
				if (m_tdata[0] !== exp_vis) begin
					$error("visible: expected %0d actual %0d", exp_vis, m_tdata[0]);
					failures++;
				end
			end
		end
	end

	function automatic logic [31:0] rand_value();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'($signed($urandom_range(16'hffff, 0)) - 32768) <<< 16;
			3: return 32'($signed($urandom_range(8'hff, 0)) - 128) <<< 12;
			default: return $urandom;
		endcase
	endfunction

	task automatic load_matrix_random();
		logic signed [31:0] z [3] = '{0, 0, 0};
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				if ($urandom_range(3) == 0 || r == c)
					send_word(fpbc_pkg::MODE_LOAD, r[1:0], c[1:0], rand_value(), z, z);
	endtask

	task automatic load_identity();
		logic signed [31:0] z [3] = '{0, 0, 0};
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				send_word(fpbc_pkg::MODE_LOAD, r[1:0], c[1:0],
					(r == c) ? 32'h0001_0000 : 32'h0, z, z);
	endtask

	// drop valid and hold off until every expected result has come
	task automatic wait_drain();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (visible_queue.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
	endtask

	// extremes, points on planes, swapped bounds, ignored mode three
	task automatic test_directed();
		logic signed [31:0] lo [3];
		logic signed [31:0] hi [3];
		logic signed [31:0] q1;
		q1 = 32'sh0001_0000;
		lo = '{0, 0, 0}; hi = lo;
		send_word(fpbc_pkg::MODE_POINT, 0, 0, 0, lo, hi);   // origin, inside
		lo = '{q1, 0, 0};
		send_word(fpbc_pkg::MODE_POINT, 0, 0, 0, lo, hi);   // on x plane
		lo = '{q1 + 1, 0, 0};
		send_word(fpbc_pkg::MODE_POINT, 0, 0, 0, lo, hi);   // just outside
		lo = '{0, -q1, q1};
		send_word(fpbc_pkg::MODE_POINT, 0, 0, 0, lo, hi);
		lo = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
		hi = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
		send_word(fpbc_pkg::MODE_POINT, 0, 0, 0, lo, hi);
		send_word(fpbc_pkg::MODE_POINT, 0, 0, 0, hi, lo);
		send_word(fpbc_pkg::MODE_BOX, 0, 0, 0, lo, hi);     // huge box
		send_word(fpbc_pkg::MODE_BOX, 0, 0, 0, hi, lo);     // swapped bounds
		lo = '{2 * q1, 0, 0}; hi = '{3 * q1, q1, q1};
		send_word(fpbc_pkg::MODE_BOX, 0, 0, 0, lo, hi);     // all corners behind
		send_word(fpbc_pkg::MODE_BOX, 0, 0, 0, hi, lo);
		lo = '{q1, 0, 0};
		send_word(fpbc_pkg::MODE_BOX, 0, 0, 0, lo, hi);     // touching
		send_word(2'd3, 2'd3, 2'd3, 32'hffff_ffff, lo, hi); // dropped
		send_word(fpbc_pkg::MODE_LOAD, 2'd3, 2'd3, 32'h8000_0000, lo, hi);
		send_word(fpbc_pkg::MODE_POINT, 0, 0, 0, lo, hi);
		send_word(fpbc_pkg::MODE_LOAD, 2'd0, 2'd3, 32'h7fff_ffff, lo, hi);
		send_word(fpbc_pkg::MODE_BOX, 0, 0, 0, lo, hi);
		wait_drain();
		load_identity();
	endtask

	task automatic test_random(int count);
		logic signed [31:0] lo [3];
		logic signed [31:0] hi [3];
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 3)
				load_matrix_random();
			for (int k = 0; k < 3; k++) begin
				lo[k] = rand_value();
				hi[k] = ($urandom_range(3) == 0) ? rand_value()
					: lo[k] + 32'($urandom_range(32'h0004_0000));
			end
			case ($urandom_range(19))
				0: send_word(2'd3, 2'($urandom), 2'($urandom), $urandom, lo, hi);
				1, 2, 3, 4, 5, 6: send_word(fpbc_pkg::MODE_POINT, 2'($urandom),
					2'($urandom), $urandom, lo, hi);
				default: send_word(fpbc_pkg::MODE_BOX, 2'($urandom), 2'($urandom),
					$urandom, lo, hi);
			endcase
		end
	endtask

	// hold the receiver while words keep coming, then pause until drained
	task automatic test_backpressure();
		logic signed [31:0] lo [3];
		logic signed [31:0] hi [3];
		int hold_cycles;
		recv_hold = 1'b1;
		fork
			begin
				hold_cycles = 0;
				while (hold_cycles < 200) begin
					@(posedge clk);
					hold_cycles++;
				end
				recv_hold = 1'b0;
			end
			for (int i = 0; i < 30; i++) begin
				lo = '{rand_value(), rand_value(), rand_value()};
				hi = '{rand_value(), rand_value(), rand_value()};
				send_word(i[0] ? fpbc_pkg::MODE_BOX : fpbc_pkg::MODE_POINT, 0, 0, 0,
					lo, hi);
			end
		join
		wait_drain();
	endtask

	initial begin
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				view_mat[r][c] = (r == c) ? 32'sh0001_0000 : 32'sh0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		send_idle_pct = 18; recv_idle_pct = 86;
		test_random(500);
		send_idle_pct = 86; recv_idle_pct = 18;
		test_random(500);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_backpressure();
		test_random(1000);
		wait_drain();
		$display("Sent %0d words: %0d loads, %0d points, %0d boxes; checked %0d results.",
			words_sent, loads_sent, points_sent, boxes_sent, results_seen);
		if (failures == 0 && visible_queue.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#50ms;
		$display("FAIL");
		$finish;
	end
endmodule
